### rtl/gradient_colour_map_assert.svh
// Assertion macros for the gradient colour map block.
`ifndef GRADIENT_COLOUR_MAP_ASSERT_SVH
`define GRADIENT_COLOUR_MAP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define GCM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcm assertion failed");
// Plain property that must hold every cycle.
`define GCM_ASSERT_ALW(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("gcm assertion failed");
`else
`define GCM_ASSERT_IMP(lbl, ante, cons)
`define GCM_ASSERT_ALW(lbl, cond)
`endif
`endif

### rtl/gcm_pkg.sv
// Shared types and constants for the gradient colour map block.
package gcm_pkg;

   localparam int MAX_STOPS = 16;
   localparam int IDX_W     = $clog2(MAX_STOPS);
   localparam int CNT_W     = 5;
   localparam int POS_W     = 17;
   localparam int COL_W     = 32;
   localparam int VAL_W     = 32;

   localparam logic [POS_W-1:0] POS_ONE  = 17'd65536;
   localparam logic [POS_W-1:0] POS_HALF = 17'd32768;

   // Register indexes
   localparam logic [1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [1:0] CSR_DISCRETE   = 2'd2;
   localparam logic [1:0] CSR_STOP_COUNT = 2'd3;

   // Commands
   localparam logic CMD_STOP = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   // Search token that walks the row of stop cells
   typedef struct packed {
      logic             active;
      logic             top;    // position is one: skip compares, carry last colour
      logic             done;
      logic             exact;  // col0 is the final colour
      logic             any;    // passed at least one stop in use
      logic [POS_W-1:0] p;
      logic [POS_W-1:0] pos0;
      logic [POS_W-1:0] pos1;
      logic [COL_W-1:0] col0;
      logic [COL_W-1:0] col1;
   } probe_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_BLEND  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

endpackage

### rtl/gradient_colour_map.sv
// Top level of the gradient colour map: registers, sequencer and row of stop cells.
//
//  channel  ports   dir  beat
//  request  req_*   in   stop write or sample to map
//  response rsp_*   out  mapped RGBA colour
//  config   csr_*   in   register write
//
// A map beat passes through the scaler (16-step divider), the row of stop
// cells, the blend lanes when blending, and the output register.
// Reset clears control and resets the configuration registers; stop storage is undefined until written.
// A held result in the output register does not block the next request.
module gradient_colour_map (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [gcm_pkg::IDX_W-1:0]         req_stop_index,
   input  logic [gcm_pkg::POS_W-1:0]         req_stop_position,
   input  logic [gcm_pkg::COL_W-1:0]         req_stop_colour,
   input  logic signed [gcm_pkg::VAL_W-1:0]  req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gcm_pkg::COL_W-1:0]         rsp_colour,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [31:0]                       csr_data
);

`include "gradient_colour_map_assert.svh"

   localparam int N = gcm_pkg::MAX_STOPS;

   gcm_pkg::state_type               state_ff, state_in;
   logic signed [31:0]               range_low_ff, range_high_ff;
   logic                             discrete_ff;
   logic [gcm_pkg::CNT_W-1:0]        count_ff;
   logic signed [31:0]               sample_ff;
   logic                             scale_start_ff;
   logic                             scale_done;
   logic [gcm_pkg::POS_W-1:0]        scale_pos;
   gcm_pkg::probe_type               probe_w [N+1];
   gcm_pkg::probe_type               probe_end;
   logic                             wr_en;
   logic [gcm_pkg::POS_W-1:0]        wr_pos;
   logic                             blend_start_ff;
   logic                             blend_done;
   logic [31:0]                      blend_colour;
   logic [gcm_pkg::POS_W-1:0]        num_w, den_w;
   logic [gcm_pkg::POS_W-1:0]        num_ff, den_ff;
   logic [31:0]                      col0_ff, col1_ff;
   logic [31:0]                      result_ff, result_in;
   logic [31:0]                      rsp_colour_ff;
   logic                             rsp_valid_ff;
   logic                             out_load;
   logic                             req_accept;

   assign req_stall  = state_ff != gcm_pkg::ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && req_command == gcm_pkg::CMD_STOP;
   assign wr_pos     = (req_stop_position > gcm_pkg::POS_ONE) ?
                       gcm_pkg::POS_ONE : req_stop_position;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= 32'sd65536;
         discrete_ff   <= 1'b0;
         count_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            gcm_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_data;
            gcm_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_data;
            gcm_pkg::CSR_DISCRETE:   discrete_ff   <= csr_data[0];
            gcm_pkg::CSR_STOP_COUNT: count_ff      <= csr_data[gcm_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_sample_value;
      end
   end

   gcm_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start_ff),
      .sample     (sample_ff),
      .range_low  (range_low_ff),
      .range_high (range_high_ff),
      .done       (scale_done),
      .pos        (scale_pos)
   );

   // Token entering the first cell
   always_comb begin
      probe_w[0]        = '0;
      probe_w[0].active = scale_done;
      probe_w[0].top    = scale_pos == gcm_pkg::POS_ONE;
      probe_w[0].p      = scale_pos;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      gcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (gcm_pkg::IDX_W'(i)),
         .in_use    (i < int'(count_ff)),
         .wr_en     (wr_en),
         .wr_idx    (req_stop_index),
         .wr_pos    (wr_pos),
         .wr_col    (req_stop_colour),
         .probe_in  (probe_w[i]),
         .probe_out (probe_w[i+1])
      );
   end

   assign probe_end = probe_w[N];
   assign num_w     = probe_end.p - probe_end.pos0;
   assign den_w     = probe_end.pos1 - probe_end.pos0;

   always_ff @(posedge clock) begin
      num_ff  <= num_w;
      den_ff  <= den_w;
      col0_ff <= probe_end.col0;
      col1_ff <= probe_end.col1;
   end

   gcm_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start_ff),
      .col0   (col0_ff),
      .col1   (col1_ff),
      .num    (num_ff),
      .den    (den_ff),
      .done   (blend_done),
      .colour (blend_colour)
   );

   assign out_load = state_ff == gcm_pkg::ST_EMIT && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      case (state_ff)
         gcm_pkg::ST_IDLE: begin
            if (req_accept && req_command == gcm_pkg::CMD_MAP) begin
               state_in = gcm_pkg::ST_SCALE;
            end
         end
         gcm_pkg::ST_SCALE: begin
            if (scale_done) begin
               state_in = gcm_pkg::ST_SEARCH;
            end
         end
         gcm_pkg::ST_SEARCH: begin
            if (probe_end.active) begin
               state_in = gcm_pkg::ST_EMIT;
               if (!probe_end.any) begin
                  result_in = '0;
               end else if (!probe_end.done || probe_end.exact) begin
                  result_in = probe_end.col0;
               end else if (discrete_ff) begin
                  result_in = ({num_w, 1'b0} < {1'b0, den_w}) ?
                              probe_end.col0 : probe_end.col1;
               end else begin
                  state_in = gcm_pkg::ST_BLEND;
               end
            end
         end
         gcm_pkg::ST_BLEND: begin
            if (blend_done) begin
               state_in  = gcm_pkg::ST_EMIT;
               result_in = blend_colour;
            end
         end
         gcm_pkg::ST_EMIT: begin
            if (out_load) begin
               state_in = gcm_pkg::ST_IDLE;
            end
         end
         default: state_in = gcm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gcm_pkg::ST_IDLE;
         scale_start_ff <= 1'b0;
         blend_start_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scale_start_ff <= req_accept && req_command == gcm_pkg::CMD_MAP;
         blend_start_ff <= state_ff == gcm_pkg::ST_SEARCH && probe_end.active &&
                           state_in == gcm_pkg::ST_BLEND;
         rsp_valid_ff   <= out_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (out_load) begin
         rsp_colour_ff <= result_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_colour = rsp_colour_ff;

   `GCM_ASSERT_IMP(a_probe_in_search, probe_end.active, state_ff == gcm_pkg::ST_SEARCH)
   `GCM_ASSERT_IMP(a_blend_in_blend, blend_done, state_ff == gcm_pkg::ST_BLEND)
   `GCM_ASSERT_IMP(a_scale_in_scale, scale_done, state_ff == gcm_pkg::ST_SCALE)
   `GCM_ASSERT_ALW(a_state_onehot, $onehot(state_ff))

endmodule

### rtl/gcm_cell.sv
// One colour stop cell: holds a stop and advances the search token by one.
module gcm_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [gcm_pkg::IDX_W-1:0]          cell_id,
   input  logic                               in_use,
   input  logic                               wr_en,
   input  logic [gcm_pkg::IDX_W-1:0]          wr_idx,
   input  logic [gcm_pkg::POS_W-1:0]          wr_pos,
   input  logic [gcm_pkg::COL_W-1:0]          wr_col,
   input  gcm_pkg::probe_type                 probe_in,
   output gcm_pkg::probe_type                 probe_out
);

   logic [gcm_pkg::POS_W-1:0] pos_ff;
   logic [gcm_pkg::COL_W-1:0] col_ff;
   gcm_pkg::probe_type        probe_in_w;
   gcm_pkg::probe_type        probe_ff;

   // Stop storage
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx == cell_id) begin
         pos_ff <= wr_pos;
         col_ff <= wr_col;
      end
   end

   // Compare against this stop
   always_comb begin
      probe_in_w = probe_in;
      if (probe_in.active && in_use && !probe_in.done) begin
         probe_in_w.any = 1'b1;
         if (!probe_in.top && pos_ff == probe_in.p) begin
            probe_in_w.done  = 1'b1;
            probe_in_w.exact = 1'b1;
            probe_in_w.col0  = col_ff;
         end else if (!probe_in.top && pos_ff > probe_in.p) begin
            probe_in_w.done = 1'b1;
            if (!probe_in.any) begin
               // below the first stop
               probe_in_w.exact = 1'b1;
               probe_in_w.col0  = col_ff;
            end else begin
               probe_in_w.pos1 = pos_ff;
               probe_in_w.col1 = col_ff;
            end
         end else begin
            probe_in_w.pos0 = pos_ff;
            probe_in_w.col0 = col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.active <= 1'b0;
      end else begin
         probe_ff.active <= probe_in_w.active;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff.top   <= probe_in_w.top;
      probe_ff.done  <= probe_in_w.done;
      probe_ff.exact <= probe_in_w.exact;
      probe_ff.any   <= probe_in_w.any;
      probe_ff.p     <= probe_in_w.p;
      probe_ff.pos0  <= probe_in_w.pos0;
      probe_ff.pos1  <= probe_in_w.pos1;
      probe_ff.col0  <= probe_in_w.col0;
      probe_ff.col1  <= probe_in_w.col1;
   end

   assign probe_out = probe_ff;

endmodule

### rtl/gcm_scale.sv
// Sample scaling: range checks and a one-bit-per-cycle restoring divider.
module gcm_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [gcm_pkg::VAL_W-1:0]   sample,
   input  logic signed [gcm_pkg::VAL_W-1:0]   range_low,
   input  logic signed [gcm_pkg::VAL_W-1:0]   range_high,
   output logic                               done,
   output logic [gcm_pkg::POS_W-1:0]          pos
);

   localparam int DW = gcm_pkg::VAL_W + 1;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic [DW-1:0]             rem_ff, rem_in;
   logic [DW-1:0]             den_ff, den_in;
   logic [15:0]               quo_ff, quo_in;
   logic [gcm_pkg::POS_W-1:0] pos_ff, pos_in;
   logic signed [DW-1:0]      diff_w;
   logic signed [DW-1:0]      span_w;
   logic [DW:0]               shl_w;
   logic                      ge_w;

   assign diff_w = DW'(sample) - DW'(range_low);
   assign span_w = DW'(range_high) - DW'(range_low);
   assign shl_w  = {rem_ff, 1'b0};
   assign ge_w   = shl_w >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      pos_in  = pos_ff;
      if (start) begin
         if (range_high == range_low) begin
            done_in = 1'b1;
            pos_in  = gcm_pkg::POS_HALF;
         end else if (sample <= range_low) begin
            done_in = 1'b1;
            pos_in  = '0;
         end else if (sample >= range_high) begin
            done_in = 1'b1;
            pos_in  = gcm_pkg::POS_ONE;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = diff_w;
            den_in  = span_w;
            quo_in  = '0;
         end
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = ge_w ? DW'(shl_w - {1'b0, den_ff}) : DW'(shl_w);
         quo_in = {quo_ff[14:0], ge_w};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            pos_in  = {1'b0, quo_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      pos_ff <= pos_in;
   end

   assign done = done_ff;
   assign pos  = pos_ff;

endmodule

### rtl/gcm_blend.sv
// Per-byte linear blend: four lanes, multiply then eight divide steps.
module gcm_blend (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gcm_pkg::COL_W-1:0] col0,
   input  logic [gcm_pkg::COL_W-1:0] col1,
   input  logic [gcm_pkg::POS_W-1:0] num,
   input  logic [gcm_pkg::POS_W-1:0] den,
   output logic                      done,
   output logic [gcm_pkg::COL_W-1:0] colour
);

   localparam int PW = gcm_pkg::POS_W;
   localparam int MW = 8 + PW;

   logic          load_ff, busy_ff, done_ff;
   logic [2:0]    cnt_ff;
   logic [PW-1:0] den_ff;
   logic [7:0]    a_ff   [4];
   logic          neg_ff [4];
   logic [MW-1:0] mul_ff [4];
   logic [PW-1:0] rem_ff [4];
   logic [7:0]    low_ff [4];
   logic [7:0]    quo_ff [4];
   logic [PW:0]   shl_w  [4];
   logic          ge_w   [4];
   logic [7:0]    res_w  [4];

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= start;
         done_ff <= busy_ff && cnt_ff == 3'd7;
         if (load_ff) begin
            busy_ff <= 1'b1;
         end else if (cnt_ff == 3'd7) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
      end
      if (load_ff) begin
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [7:0] ca_w, cb_w, mag_w;

      assign ca_w     = col0[8*k +: 8];
      assign cb_w     = col1[8*k +: 8];
      assign mag_w    = (cb_w >= ca_w) ? cb_w - ca_w : ca_w - cb_w;
      assign shl_w[k] = {rem_ff[k], low_ff[k][7]};
      assign ge_w[k]  = shl_w[k] >= {1'b0, den_ff};
      // floor of a negative step rounds the magnitude up
      assign res_w[k] = neg_ff[k] ?
         a_ff[k] - quo_ff[k] - {7'd0, rem_ff[k] != '0} : a_ff[k] + quo_ff[k];

      always_ff @(posedge clock) begin
         if (start) begin
            a_ff[k]   <= ca_w;
            neg_ff[k] <= cb_w < ca_w;
            mul_ff[k] <= MW'(mag_w) * MW'(num);
         end
         if (load_ff) begin
            rem_ff[k] <= PW'(mul_ff[k][MW-1:8]);
            low_ff[k] <= mul_ff[k][7:0];
            quo_ff[k] <= '0;
         end else if (busy_ff) begin
            rem_ff[k] <= ge_w[k] ? PW'(shl_w[k] - {1'b0, den_ff}) : PW'(shl_w[k]);
            low_ff[k] <= {low_ff[k][6:0], 1'b0};
            quo_ff[k] <= {quo_ff[k][6:0], ge_w[k]};
         end
      end
   end

   assign done   = done_ff;
   assign colour = {res_w[3], res_w[2], res_w[1], res_w[0]};

endmodule

### tb/sv/gcm_colour_checker.sv
// Checker for the gradient colour map: watches the channels, predicts colours, compares.
`timescale 1ns / 100ps

module gcm_colour_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_command,
   input  logic [gcm_pkg::IDX_W-1:0]         req_stop_index,
   input  logic [gcm_pkg::POS_W-1:0]         req_stop_position,
   input  logic [gcm_pkg::COL_W-1:0]         req_stop_colour,
   input  logic signed [gcm_pkg::VAL_W-1:0]  req_sample_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [gcm_pkg::COL_W-1:0]         rsp_colour,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [31:0]                       csr_data,
   output int                                fail_count,
   output int                                colours_pending,
   output int                                colours_checked
);

   // shadow of the block's registers and stop storage
   logic signed [31:0]        shadow_low;
   logic signed [31:0]        shadow_high;
   logic                      shadow_discrete;
   logic [4:0]                shadow_count;
   logic [gcm_pkg::POS_W-1:0] shadow_pos [gcm_pkg::MAX_STOPS];
   logic [gcm_pkg::COL_W-1:0] shadow_col [gcm_pkg::MAX_STOPS];

   logic [gcm_pkg::COL_W-1:0] expected_colours [$];

   // scale the sample to a position, then look it up among the stops in use
   function automatic logic [gcm_pkg::COL_W-1:0] predict_colour(logic signed [31:0] sample);
      longint      s, lo, hi, p, p0, p1, a, b, v;
      int          n, i;
      logic [31:0] c;
      s  = sample;
      lo = shadow_low;
      hi = shadow_high;
      if (hi == lo) p = 32768;
      else if (s <= lo) p = 0;
      else if (s >= hi) p = 65536;
      else p = ((s - lo) * 65536) / (hi - lo);
      n = (shadow_count > gcm_pkg::MAX_STOPS) ? gcm_pkg::MAX_STOPS : int'(shadow_count);
      if (n == 0) return '0;
      if (p >= 65536) return shadow_col[n-1];
      for (i = 0; i < n; i++) begin
         if (shadow_pos[i] == p) return shadow_col[i];
         if (shadow_pos[i] > p) break;
      end
      if (i == n) return shadow_col[n-1];
      if (i == 0) return shadow_col[0];
      p0 = shadow_pos[i-1];
      p1 = shadow_pos[i];
      if (shadow_discrete)
         return (2 * (p - p0) < (p1 - p0)) ? shadow_col[i-1] : shadow_col[i];
      // per-byte blend with floor
      for (int k = 0; k < 4; k++) begin
         a = shadow_col[i-1][8*k +: 8];
         b = shadow_col[i][8*k +: 8];
         v = (a * (p1 - p0) + (b - a) * (p - p0)) / (p1 - p0);
         c[8*k +: 8] = v[7:0];
      end
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_low      = 0;
         shadow_high     = 65536;
         shadow_discrete = 1'b0;
         shadow_count    = '0;
         fail_count      = 0;
         colours_checked = 0;
         expected_colours.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               gcm_pkg::CSR_RANGE_LOW:  shadow_low      = csr_data;
               gcm_pkg::CSR_RANGE_HIGH: shadow_high     = csr_data;
               gcm_pkg::CSR_DISCRETE:   shadow_discrete = csr_data[0];
               gcm_pkg::CSR_STOP_COUNT: shadow_count    = csr_data[4:0];
               default: ;
            endcase
         end
         // request beat
         if (req_valid && !req_stall) begin
            if (req_command == gcm_pkg::CMD_STOP) begin
               shadow_pos[req_stop_index] = (req_stop_position > gcm_pkg::POS_ONE) ?
                                            gcm_pkg::POS_ONE : req_stop_position;
               shadow_col[req_stop_index] = req_stop_colour;
            end else begin
               expected_colours = {expected_colours, predict_colour(req_sample_value)};
            end
         end
         // response beat
         if (rsp_valid && !rsp_stall) begin
            if (expected_colours.size() == 0) begin
               $error("colour: unexpected beat, actual %h", rsp_colour);
               fail_count++;
            end else begin
               logic [gcm_pkg::COL_W-1:0] want;
               want = expected_colours.pop_front();
               colours_checked++;
               if (rsp_colour !== want) begin
                  $error("colour: expected %h, actual %h", want, rsp_colour);
                  fail_count++;
               end
            end
         end
      end
      colours_pending = expected_colours.size();
   end

endmodule

### tb/sv/tb_gradient_colour_map.sv
// Testbench top for the gradient colour map: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_gradient_colour_map;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_command;
   logic [gcm_pkg::IDX_W-1:0]        req_stop_index;
   logic [gcm_pkg::POS_W-1:0]        req_stop_position;
   logic [gcm_pkg::COL_W-1:0]        req_stop_colour;
   logic signed [gcm_pkg::VAL_W-1:0] req_sample_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [gcm_pkg::COL_W-1:0]        rsp_colour;
   logic                             csr_we;
   logic [1:0]                       csr_index;
   logic [31:0]                      csr_data;

   int fail_count, colours_pending, colours_checked;
   int beats_sent, csr_writes;
   bit long_hold_req;   // receiver holds off for a long stretch
   bit no_gaps;         // both sides run without idling

   gradient_colour_map u_dut (.*);

   gcm_colour_checker u_checker (.*);

   // 100 MHz clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stall before each beat, one long hold on request
   initial begin
      int n;
      rsp_stall = 1'b1;
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 7);
         if (long_hold_req) begin
            n = 400;
            long_hold_req = 1'b0;
         end
         rsp_stall = (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(logic cmd, logic [gcm_pkg::IDX_W-1:0] idx,
                            logic [gcm_pkg::POS_W-1:0] pos,
                            logic [gcm_pkg::COL_W-1:0] col, logic signed [31:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_command       = cmd;
      req_stop_index    = idx;
      req_stop_position = pos;
      req_stop_colour   = col;
      req_sample_value  = val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_map(logic signed [31:0] val);
      send_beat(gcm_pkg::CMD_MAP, gcm_pkg::IDX_W'($urandom), gcm_pkg::POS_W'($urandom),
                $urandom, val);
   endtask

   task automatic send_stop(int idx, int pos, logic [31:0] col);
      send_beat(gcm_pkg::CMD_STOP, gcm_pkg::IDX_W'(idx), gcm_pkg::POS_W'(pos), col,
                $urandom);
   endtask

   // drain: all colours back, then latency margin for trailing stop beats
   task automatic settle();
      req_valid = 1'b0;
      while (colours_pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_we    = 1'b0;
      csr_writes++;
   endtask

   // fill all stops with ascending random positions and random colours
   task automatic load_ramp();
      int pos_list [gcm_pkg::MAX_STOPS];
      for (int i = 0; i < gcm_pkg::MAX_STOPS; i++) pos_list[i] = $urandom_range(0, 65536);
      pos_list.sort();
      if ($urandom_range(0, 1)) pos_list[0] = 0;
      if ($urandom_range(0, 1)) pos_list[gcm_pkg::MAX_STOPS-1] = 65536;
      for (int i = 0; i < gcm_pkg::MAX_STOPS; i++) send_stop(i, pos_list[i], $urandom);
   endtask

   // random sample, mostly inside the current range
   function automatic logic [31:0] pick_sample(longint lo, longint hi);
      longint span;
      if ($urandom_range(0, 9) == 0 || hi <= lo) return $urandom;
      span = hi - lo;
      if (span <= 65536 && $urandom_range(0, 2) == 0)
         return 32'(lo + $urandom_range(0, 32'(span)));
      return 32'(lo + longint'((real'(span) * $urandom_range(0, 100000)) / 100000.0));
   endfunction

   initial begin
      longint lo, hi;
      int     items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = gcm_pkg::CMD_STOP;
      req_stop_index = '0;
      req_stop_position = '0;
      req_stop_colour = '0;
      req_sample_value = '0;
      csr_we = 1'b0;
      csr_index = gcm_pkg::CSR_RANGE_LOW;
      csr_data = '0;
      beats_sent = 0;
      csr_writes = 0;
      long_hold_req = 1'b0;
      no_gaps = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: no stops in use gives colour zero
      send_map(32'sd100);
      send_map(32'h8000_0000);
      settle();
      // even ramp, first stop above zero, one position written too large
      for (int i = 0; i < gcm_pkg::MAX_STOPS; i++)
         send_stop(i, 2048 + i * 4096, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      send_stop(gcm_pkg::MAX_STOPS-1, 17'h1FFFF, 32'h1234_5678);
      settle();
      write_reg(gcm_pkg::CSR_STOP_COUNT, 16);
      send_map(32'sd0);            // below first stop
      send_map(32'sd2048);         // exact stop
      send_map(32'sd4096);         // between stops
      send_map(32'sd6143);
      send_map(32'sd65536);        // position one
      send_map(32'h7FFF_FFFF);
      send_map(32'h8000_0000);
      settle();
      write_reg(gcm_pkg::CSR_DISCRETE, 1);
      send_map(32'sd4095);         // just below half
      send_map(32'sd4096);         // exactly half
      send_map(32'sd60000);        // between the last two stops
      settle();
      write_reg(gcm_pkg::CSR_RANGE_LOW, 32'sd1000);
      write_reg(gcm_pkg::CSR_RANGE_HIGH, 32'sd1000);   // zero range
      write_reg(gcm_pkg::CSR_STOP_COUNT, 20);          // count beyond the stop array
      send_map(32'sd5);
      send_map(32'sd1000);
      settle();
      write_reg(gcm_pkg::CSR_RANGE_LOW, 32'h8000_0000);
      write_reg(gcm_pkg::CSR_RANGE_HIGH, 32'h7FFF_FFFF);
      write_reg(gcm_pkg::CSR_DISCRETE, 0);
      send_map(32'h8000_0001);
      send_map(32'sd0);
      send_map(32'h7FFF_FFFE);

      // random phases
      for (int phase = 0; phase < 28; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0: begin lo = -2147483648; hi = 2147483647; end
            1: begin lo = $signed($urandom); hi = lo; end
            2: begin lo = $signed($urandom); hi = $signed($urandom); end
            3: begin lo = 0; hi = 65536; end
            default: begin
               lo = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
               hi = lo + $urandom_range(1, 1 << 20);
            end
         endcase
         write_reg(gcm_pkg::CSR_RANGE_LOW, lo[31:0]);
         write_reg(gcm_pkg::CSR_RANGE_HIGH, hi[31:0]);
         lo = $signed(lo[31:0]);
         hi = $signed(hi[31:0]);
         write_reg(gcm_pkg::CSR_DISCRETE, $urandom_range(0, 1));
         write_reg(gcm_pkg::CSR_STOP_COUNT,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) :
                                                 $urandom_range(1, 16));
         no_gaps = (phase % 7 == 3);
         load_ramp();
         if (phase == 5) long_hold_req = 1'b1;
         items = 50;
         for (int k = 0; k < items; k++) begin
            if (phase == 5) no_gaps = 1'b1;
            if (k == items / 2 && phase % 4 == 1) begin
               // sender pause
               req_valid = 1'b0;
               while (colours_pending != 0) @(negedge clock);
            end
            if ($urandom_range(0, 9) == 0)
               send_stop($urandom_range(0, 15), $urandom_range(0, 131071), $urandom);
            else
               send_map(pick_sample(lo, hi));
         end
      end

      // wrap up
      settle();
      no_gaps = 1'b0;
      $display("Run covered %0d request beats, %0d colours checked, %0d register writes.",
               beats_sent, colours_checked, csr_writes);
      $display("Ranges included full-scale, zero-width and reversed; both blend modes.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/gcm_pkg.sv
rtl/gcm_cell.sv
rtl/gcm_scale.sv
rtl/gcm_blend.sv
rtl/gradient_colour_map.sv
tb/sv/gcm_colour_checker.sv
tb/sv/tb_gradient_colour_map.sv
